FILE: rtl/nbg_pkg.sv
// Shared types and constants for the 1-D gravity step engine.
`timescale 1ns / 1ps
package nbg_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DIV_W      = 64;
	localparam int DSR_W      = 49;

	localparam logic [47:0] MAXV48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] MINV48 = 48'h8000_0000_0000;
	localparam logic [60:0] AT2_CAP = 61'h1000_0000_0000_0000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [47:0] pos;
		logic [47:0] vel;
	} pv_t;

	typedef struct packed {
		logic [15:0] mass;
		logic [47:0] cf;
		logic        lsat;
		logic [47:0] nf;
		logic        coin;
		logic        sat;
	} bm_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/nbg_ram.sv
// Generic one-write, one-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module nbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/nbg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nbg_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [nbg_pkg::DIV_W-1:0]      dividend,
	input  logic [nbg_pkg::DSR_W-1:0]      divisor,
	output logic [nbg_pkg::DIV_W-1:0]      quotient,
	output nbg_pkg::div_stat_t             stat
);

	localparam int CW = $clog2(nbg_pkg::DIV_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [nbg_pkg::DIV_W-1:0]   dvd_q;
	logic [nbg_pkg::DSR_W-1:0]   dsr_q;
	logic [nbg_pkg::DSR_W-1:0]   rem_q;
	logic [nbg_pkg::DSR_W:0]     trial;
	logic                        fit;

	assign trial = {rem_q, dvd_q[nbg_pkg::DIV_W-1]};
	assign fit   = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(nbg_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? nbg_pkg::DSR_W'(trial - {1'b0, dsr_q})
				: trial[nbg_pkg::DSR_W-1:0];
			dvd_q <= {dvd_q[nbg_pkg::DIV_W-2:0], fit};
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/nbody_1d_gravity_step.sv
// Top level: sequencer and datapath of the 1-D gravity step engine.
// A load word goes through a multiply state and a write state. A step word walks
// every ordered pair of active bodies, each with up to two quotients from the
// shared radix-2 divider, then updates each body with one division for the
// acceleration (when its mass is nonzero) and three passes through the shared
// 64x16 multiplier. Results leave through an output register, so a new word is
// taken while the last result still waits. Body state sits in two RAMs with
// registered reads.
`timescale 1ns / 1ps
module nbody_1d_gravity_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [3:0]         point_index,
	input  logic [15:0]        body_mass,
	input  logic signed [47:0] start_position,
	input  logic signed [47:0] start_velocity,
	input  logic signed [47:0] start_acceleration,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         out_index,
	output logic signed [47:0] new_position,
	output logic signed [47:0] new_velocity,
	output logic               coincident_flag,
	output logic               saturated_flag,
	output logic               last_result
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_LD_MUL, ST_LD_WR,
		ST_P1_RDI, ST_P1_LATI, ST_P1_RDJ, ST_P1_LATJ, ST_P1_CHK,
		ST_P1_DIV1, ST_P1_DIV2, ST_P1_WR,
		ST_P2_RD, ST_P2_LAT, ST_P2_DIV, ST_P2_M1, ST_P2_M2, ST_P2_M3, ST_P2_M4,
		ST_P2_SUM, ST_P2_OUT
	} state_t;

	state_t          st_q;
	logic [4:0]      pc_q;
	nbg_pkg::cnt_t   n_q;
	nbg_pkg::cnt_t   i_q;
	nbg_pkg::cnt_t   j_q;
	logic            out_valid_q;

	logic [3:0]      idx_q;
	logic [15:0]     mass_q;
	logic [47:0]     pos_q;
	logic [47:0]     vel_q;
	logic [47:0]     acc_q;
	logic [15:0]     ts_q;

	logic [47:0]     xi_q;
	logic [15:0]     mi_q;
	logic [47:0]     cf_q;
	logic            ls_q;
	logic [52:0]     g_q;
	logic            coin_q;
	logic            sat_q;
	logic [48:0]     dx_q;
	logic [31:0]     p_q;

	logic [47:0]     x_q;
	logic [47:0]     v_q;
	logic [47:0]     am_q;
	logic            asg_q;
	logic [63:0]     dvf_q;
	logic [55:0]     vt_q;
	logic [60:0]     at2_q;
	logic [47:0]     nx_q;
	logic [47:0]     nv_q;
	logic [79:0]     mul_p_q;

	logic [3:0]      oidx_q;
	logic [47:0]     opos_q;
	logic [47:0]     ovel_q;
	logic            ocoin_q;
	logic            osat_q;
	logic            olast_q;

	logic            in_acc;
	logic            out_free;
	logic            out_load;
	logic            load_ok;
	nbg_pkg::idx_t   rd_addr;

	logic            a_we;
	nbg_pkg::idx_t   a_waddr;
	nbg_pkg::pv_t    a_wdata;
	nbg_pkg::pv_t    a_rd;
	logic            b_we;
	nbg_pkg::idx_t   b_waddr;
	nbg_pkg::bm_t    b_wdata;
	nbg_pkg::bm_t    b_rd;

	logic            div_start;
	logic [63:0]     div_dvd;
	logic [48:0]     div_dsr;
	logic [63:0]     div_quo;
	nbg_pkg::div_stat_t div_st;

	logic [63:0]     mul_a;
	logic [15:0]     mul_b;

	logic [47:0]     acc_mag;
	logic [47:0]     v_mag;
	logic [47:0]     nf_mag;
	logic [48:0]     dx_mag;
	logic            t_big;
	logic [47:0]     q_amt;
	logic            q_sat;
	logic [53:0]     nf_sum;
	logic            nf_sat;
	logic [47:0]     nf_val;
	logic [63:0]     ld_prod;
	logic            ld_sat;
	logic [47:0]     ld_cf;
	logic [63:0]     x_sum;
	logic [63:0]     v_sum;
	logic [48:0]     x_res;
	logic [48:0]     v_res;
	logic [55:0]     dv;
	logic            last_now;

	function automatic logic [48:0] sat48(input logic [63:0] s);
		logic over;
		over = !((&s[63:47]) || !(|s[63:47]));
		if (!over) begin
			return {1'b0, s[47:0]};
		end
		return {1'b1, s[63] ? nbg_pkg::MINV48 : nbg_pkg::MAXV48};
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = st_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = st_q == ST_P2_OUT && out_free;
	assign load_ok   = int'(idx_q) < nbg_pkg::MAX_POINTS;
	assign last_now  = nbg_pkg::cnt_t'(i_q + 1'b1) == n_q;

	assign out_index       = oidx_q;
	assign new_position    = opos_q;
	assign new_velocity    = ovel_q;
	assign coincident_flag = ocoin_q;
	assign saturated_flag  = osat_q;
	assign last_result     = olast_q;

	assign acc_mag = acc_q[47] ? 48'(-acc_q) : acc_q;
	assign v_mag   = v_q[47] ? 48'(-v_q) : v_q;
	assign nf_mag  = b_rd.nf[47] ? 48'(-b_rd.nf) : b_rd.nf;
	assign dx_mag  = dx_q[48] ? 49'(-dx_q) : dx_q;
	assign t_big   = |div_quo[63:40];

	always_comb begin
		rd_addr = (st_q == ST_P1_RDJ) ? j_q[nbg_pkg::IDX_W-1:0] : i_q[nbg_pkg::IDX_W-1:0];

		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_LD_MUL: begin
				mul_a = 64'(acc_mag);
				mul_b = mass_q;
			end
			ST_P2_M1: begin
				mul_a = 64'(am_q);
				mul_b = ts_q;
			end
			ST_P2_M2: begin
				mul_a = 64'(v_mag);
				mul_b = ts_q;
			end
			ST_P2_M3: begin
				mul_a = dvf_q;
				mul_b = ts_q;
			end
			default: begin
			end
		endcase

		div_start = 1'b0;
		div_dvd   = {8'b0, p_q, 24'b0};
		div_dsr   = dx_mag;
		case (st_q)
			ST_P1_CHK: begin
				div_start = dx_q != '0;
			end
			ST_P1_DIV1: begin
				div_start = div_st.done && !t_big;
				div_dvd   = {div_quo[39:0], 24'b0};
			end
			ST_P2_LAT: begin
				div_start = b_rd.mass != '0;
				div_dvd   = 64'(nf_mag);
				div_dsr   = 49'(b_rd.mass);
			end
			default: begin
			end
		endcase

		if (st_q == ST_P1_DIV1) begin
			q_amt = nbg_pkg::MAXV48;
			q_sat = 1'b1;
		end else begin
			q_sat = |div_quo[63:47];
			q_amt = q_sat ? nbg_pkg::MAXV48 : div_quo[47:0];
		end

		nf_sum = {{6{cf_q[47]}}, cf_q} + {g_q[52], g_q};
		nf_sat = !((&nf_sum[53:47]) || !(|nf_sum[53:47]));
		nf_val = nf_sat ? (nf_sum[53] ? nbg_pkg::MINV48 : nbg_pkg::MAXV48) : nf_sum[47:0];

		ld_prod = mul_p_q[63:0];
		ld_sat  = acc_q[47] ? (ld_prod > 64'h8000_0000_0000) : (|ld_prod[63:47]);
		if (ld_sat) begin
			ld_cf = acc_q[47] ? nbg_pkg::MINV48 : nbg_pkg::MAXV48;
		end else begin
			ld_cf = acc_q[47] ? 48'(-ld_prod[47:0]) : ld_prod[47:0];
		end

		dv    = dvf_q[63:8];
		x_sum = {{16{x_q[47]}}, x_q}
			+ (v_q[47] ? 64'(-{8'b0, vt_q}) : {8'b0, vt_q})
			+ (asg_q ? 64'(-{3'b0, at2_q}) : {3'b0, at2_q});
		v_sum = {{16{v_q[47]}}, v_q} + (asg_q ? 64'(-{8'b0, dv}) : {8'b0, dv});
		x_res = sat48(x_sum);
		v_res = sat48(v_sum);

		a_we    = (st_q == ST_LD_WR && load_ok) || out_load;
		a_waddr = (st_q == ST_LD_WR) ? nbg_pkg::idx_t'(idx_q) : i_q[nbg_pkg::IDX_W-1:0];
		a_wdata = (st_q == ST_LD_WR) ? {pos_q, vel_q} : {nx_q, nv_q};

		b_we    = (st_q == ST_LD_WR && load_ok) || st_q == ST_P1_WR;
		b_waddr = a_waddr;
		if (st_q == ST_LD_WR) begin
			b_wdata = {mass_q, ld_cf, ld_sat, 48'b0, 1'b0, 1'b0};
		end else begin
			b_wdata = {mi_q, cf_q, ls_q, nf_val, coin_q, sat_q || nf_sat};
		end
	end

	nbg_ram #(
		.WIDTH($bits(nbg_pkg::pv_t)),
		.DEPTH(nbg_pkg::MAX_POINTS)
	) u_pv_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (rd_addr),
		.rdata (a_rd)
	);

	nbg_ram #(
		.WIDTH($bits(nbg_pkg::bm_t)),
		.DEPTH(nbg_pkg::MAX_POINTS)
	) u_bm_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (rd_addr),
		.rdata (b_rd)
	);

	nbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.stat     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pc_q        <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (opcode == nbg_pkg::OP_LOAD) begin
							st_q <= ST_LD_MUL;
						end else begin
							i_q <= '0;
							if (int'(pc_q) > nbg_pkg::MAX_POINTS) begin
								n_q  <= nbg_pkg::cnt_t'(nbg_pkg::MAX_POINTS);
								st_q <= ST_P1_RDI;
							end else begin
								n_q  <= nbg_pkg::cnt_t'(pc_q);
								st_q <= (pc_q == '0) ? ST_IDLE : ST_P1_RDI;
							end
						end
					end
				end
				ST_LD_MUL: st_q <= ST_LD_WR;
				ST_LD_WR:  st_q <= ST_IDLE;
				ST_P1_RDI: st_q <= ST_P1_LATI;
				ST_P1_LATI: begin
					j_q  <= '0;
					st_q <= ST_P1_RDJ;
				end
				ST_P1_RDJ: begin
					if (j_q == n_q) begin
						st_q <= ST_P1_WR;
					end else if (j_q == i_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						st_q <= ST_P1_LATJ;
					end
				end
				ST_P1_LATJ: st_q <= ST_P1_CHK;
				ST_P1_CHK: begin
					if (dx_q == '0) begin
						j_q  <= j_q + 1'b1;
						st_q <= ST_P1_RDJ;
					end else begin
						st_q <= ST_P1_DIV1;
					end
				end
				ST_P1_DIV1: begin
					if (div_st.done) begin
						if (t_big) begin
							j_q  <= j_q + 1'b1;
							st_q <= ST_P1_RDJ;
						end else begin
							st_q <= ST_P1_DIV2;
						end
					end
				end
				ST_P1_DIV2: begin
					if (div_st.done) begin
						j_q  <= j_q + 1'b1;
						st_q <= ST_P1_RDJ;
					end
				end
				ST_P1_WR: begin
					if (last_now) begin
						i_q  <= '0;
						st_q <= ST_P2_RD;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= ST_P1_RDI;
					end
				end
				ST_P2_RD: st_q <= ST_P2_LAT;
				ST_P2_LAT: st_q <= (b_rd.mass == '0) ? ST_P2_M1 : ST_P2_DIV;
				ST_P2_DIV: begin
					if (div_st.done) begin
						st_q <= ST_P2_M1;
					end
				end
				ST_P2_M1:  st_q <= ST_P2_M2;
				ST_P2_M2:  st_q <= ST_P2_M3;
				ST_P2_M3:  st_q <= ST_P2_M4;
				ST_P2_M4:  st_q <= ST_P2_SUM;
				ST_P2_SUM: st_q <= ST_P2_OUT;
				ST_P2_OUT: begin
					if (out_free) begin
						i_q  <= i_q + 1'b1;
						st_q <= last_now ? ST_IDLE : ST_P2_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (in_acc) begin
			idx_q  <= point_index;
			mass_q <= body_mass;
			pos_q  <= start_position;
			vel_q  <= start_velocity;
			acc_q  <= start_acceleration;
			ts_q   <= time_step;
		end
		case (st_q)
			ST_P1_LATI: begin
				xi_q   <= a_rd.pos;
				mi_q   <= b_rd.mass;
				cf_q   <= b_rd.cf;
				ls_q   <= b_rd.lsat;
				sat_q  <= b_rd.lsat;
				coin_q <= 1'b0;
				g_q    <= '0;
			end
			ST_P1_LATJ: begin
				dx_q <= {xi_q[47], xi_q} - {a_rd.pos[47], a_rd.pos};
				p_q  <= mi_q * b_rd.mass;
			end
			ST_P1_CHK: begin
				if (dx_q == '0) begin
					coin_q <= 1'b1;
				end
			end
			ST_P1_DIV1, ST_P1_DIV2: begin
				if (div_st.done && (st_q == ST_P1_DIV2 || t_big)) begin
					sat_q <= sat_q || q_sat;
					g_q   <= dx_q[48] ? g_q + 53'(q_amt) : g_q - 53'(q_amt);
				end
			end
			ST_P2_LAT: begin
				x_q    <= a_rd.pos;
				v_q    <= a_rd.vel;
				coin_q <= b_rd.coin;
				sat_q  <= b_rd.sat;
				asg_q  <= b_rd.nf[47];
				am_q   <= '0;
			end
			ST_P2_DIV: begin
				if (div_st.done) begin
					am_q <= div_quo[47:0];
				end
			end
			ST_P2_M2: dvf_q <= mul_p_q[63:0];
			ST_P2_M3: vt_q  <= mul_p_q[63:8];
			ST_P2_M4: begin
				at2_q <= (mul_p_q[79:17] > 63'(nbg_pkg::AT2_CAP)) ? nbg_pkg::AT2_CAP
					: mul_p_q[77:17];
			end
			ST_P2_SUM: begin
				nx_q  <= x_res[47:0];
				nv_q  <= v_res[47:0];
				sat_q <= sat_q || x_res[48] || v_res[48];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			oidx_q  <= 4'(i_q);
			opos_q  <= nx_q;
			ovel_q  <= nv_q;
			ocoin_q <= coin_q;
			osat_q  <= sat_q;
			olast_q <= last_now;
		end
	end

`ifndef NO_ASSERTIONS
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy) else $error("divider restarted while busy");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> $past(div_st.busy)) else $error("divider done without work");
	a_pv_write: assert property (@(posedge clk) disable iff (!arst_n)
		a_we |-> (st_q == ST_LD_WR || st_q == ST_P2_OUT))
		else $error("position RAM written outside load or update");
	a_pair_ok: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_P1_LATJ |-> (j_q < n_q && j_q != i_q))
		else $error("pair index out of range");
	a_body_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_P1_WR || st_q == ST_P2_OUT) |-> i_q < n_q)
		else $error("body index out of range");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the 1-D gravity step engine: a directed table and random words.
`timescale 1ns / 1ps
module testbench;

	localparam int IDLE_LIMIT = 300000;
	localparam longint unsigned STEP_CAP = 64'h1000_0000_0000_0000;
	localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint MIN48 = -64'sh0000_8000_0000_0000;
	localparam int RANDOM_WORDS = 300;

	typedef struct {
		logic [3:0]  idx;
		logic [47:0] pos;
		logic [47:0] vel;
		logic        coin;
		logic        sat;
		logic        last;
	} body_result_t;

	typedef struct {
		logic        op;
		logic [3:0]  idx;
		logic [15:0] mass;
		logic [47:0] pos;
		logic [47:0] vel;
		logic [47:0] acc;
		logic [15:0] ts;
		int          cnt;
		bit          typed;
		body_result_t res;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [3:0] point_index;
	logic [15:0] body_mass;
	logic signed [47:0] start_position;
	logic signed [47:0] start_velocity;
	logic signed [47:0] start_acceleration;
	logic [15:0] time_step;
	logic out_valid;
	logic out_stall;
	logic [3:0] out_index;
	logic signed [47:0] new_position;
	logic signed [47:0] new_velocity;
	logic coincident_flag;
	logic saturated_flag;
	logic last_result;

	longint body_pos[16];
	longint body_vel[16];
	longint body_force[16];
	longint sum_force[16];
	longint unsigned body_wt[16];
	bit load_sat[16];
	bit loaded[16];
	int unsigned active_count = 0;
	bit sat_hit;

	body_result_t result_q[$];
	table_row_t dir_tab[$];
	bit typed_use;
	body_result_t typed_res;
	bit hold_req;

	int errors = 0;
	int words_sent;
	int steps_sent;
	int results_seen = 0;
	int cfg_writes;
	int idle_cycles = 0;

	nbody_1d_gravity_step DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.point_index(point_index),
		.body_mass(body_mass),
		.start_position(start_position),
		.start_velocity(start_velocity),
		.start_acceleration(start_acceleration),
		.time_step(time_step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_index(out_index),
		.new_position(new_position),
		.new_velocity(new_velocity),
		.coincident_flag(coincident_flag),
		.saturated_flag(saturated_flag),
		.last_result(last_result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat48(longint v);
		if (v > MAX48) begin
			sat_hit = 1'b1;
			return MAX48;
		end
		if (v < MIN48) begin
			sat_hit = 1'b1;
			return MIN48;
		end
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint with_sign(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return (p > {64'd0, STEP_CAP}) ? STEP_CAP : p[63:0];
	endfunction

	task automatic store_body();
		int k;
		longint a;
		k = point_index;
		a = longint'(start_acceleration);
		sat_hit = 1'b0;
		body_wt[k] = body_mass;
		body_pos[k] = longint'(start_position);
		body_vel[k] = longint'(start_velocity);
		body_force[k] = sat48(with_sign(mag(a) * body_wt[k], a < 0));
		load_sat[k] = sat_hit;
	endtask

	task automatic advance_system(logic [15:0] ts);
		int n;
		longint g;
		longint dx;
		longint a;
		longint v;
		longint x;
		longint unsigned r;
		longint unsigned p;
		longint unsigned t;
		longint unsigned q;
		longint unsigned m;
		longint unsigned dv;
		longint unsigned vt;
		longint unsigned at2;
		bit cf[16];
		bit sf[16];
		body_result_t res;
		n = (active_count > 16) ? 16 : active_count;
		for (int i = 0; i < n; i++) begin
			g = 0;
			cf[i] = 1'b0;
			sat_hit = load_sat[i];
			for (int j = 0; j < n; j++) begin
				if (i == j) continue;
				dx = body_pos[i] - body_pos[j];
				if (dx == 0) begin
					cf[i] = 1'b1;
					continue;
				end
				r = mag(dx);
				p = body_wt[i] * body_wt[j];
				t = (p << 24) / r;
				if (t >= (64'd1 << 40)) begin
					q = MAX48;
					sat_hit = 1'b1;
				end else begin
					q = (t << 24) / r;
					if (q > MAX48) begin
						q = MAX48;
						sat_hit = 1'b1;
					end
				end
				g += (dx < 0) ? longint'(q) : -longint'(q);
			end
			sum_force[i] = sat48(body_force[i] + g);
			sf[i] = sat_hit;
		end
		for (int i = 0; i < n; i++) begin
			m = body_wt[i];
			a = (m != 0) ? sum_force[i] / longint'(m) : 0;
			v = body_vel[i];
			x = body_pos[i];
			sat_hit = sf[i];
			dv = mul_shift(mag(a), ts, 8);
			vt = mul_shift(mag(v), ts, 8);
			at2 = mul_shift(mag(a), longint'(ts) * longint'(ts), 17);
			x = sat48(x + with_sign(vt, v < 0) + with_sign(at2, a < 0));
			v = sat48(v + with_sign(dv, a < 0));
			body_pos[i] = x;
			body_vel[i] = v;
			res.idx = 4'(i);
			res.pos = x[47:0];
			res.vel = v[47:0];
			res.coin = cf[i];
			res.sat = sat_hit;
			res.last = (i + 1 == n);
			result_q.push_back(res);
		end
	endtask

	always @(posedge clk) begin
		body_result_t e;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (opcode == nbg_pkg::OP_LOAD) begin
					store_body();
				end else begin
					advance_system(time_step);
					if (typed_use && result_q.size() > 0)
						result_q[result_q.size() - 1] = typed_res;
				end
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				active_count = cfg_data;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				results_seen++;
				if (result_q.size() == 0) begin
					$error("result word with nothing expected, index %0d", out_index);
					errors++;
				end else begin
					e = result_q.pop_front();
					if (out_index !== e.idx) begin
						$error("out_index exp %0d got %0d", e.idx, out_index);
						errors++;
					end
					if (new_position !== e.pos) begin
						$error("new_position exp %h got %h", e.pos, new_position);
						errors++;
					end
					if (new_velocity !== e.vel) begin
						$error("new_velocity exp %h got %h", e.vel, new_velocity);
						errors++;
					end
					if (coincident_flag !== e.coin) begin
						$error("coincident_flag exp %0d got %0d", e.coin, coincident_flag);
						errors++;
					end
					if (saturated_flag !== e.sat) begin
						$error("saturated_flag exp %0d got %0d", e.sat, saturated_flag);
						errors++;
					end
					if (last_result !== e.last) begin
						$error("last_result exp %0d got %0d", e.last, last_result);
						errors++;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int r;
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (4000) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(20, 80)) @(negedge clk);
					out_stall <= 1'b0;
				end else if (r < 20) begin
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 48'(longint'($urandom_range(0, 33554432)) - 64'sd16777216);
		if (r < 9)
			return rand48();
		return (r[0]) ? nbg_pkg::MAXV48 : nbg_pkg::MINV48;
	endfunction

	function automatic logic [15:0] rand_mass();
		return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 300));
	endfunction

	task automatic send_word(logic op, logic [3:0] idx, logic [15:0] m, logic [47:0] x,
		logic [47:0] v, logic [47:0] a, logic [15:0] ts);
		@(negedge clk);
		opcode <= op;
		point_index <= idx;
		body_mass <= m;
		start_position <= x;
		start_velocity <= v;
		start_acceleration <= a;
		time_step <= ts;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (op == nbg_pkg::OP_STEP) steps_sent++;
		if (op == nbg_pkg::OP_LOAD) loaded[idx] = 1'b1;
	endtask

	task automatic gap_after();
		int r;
		int g;
		r = $urandom_range(0, 99);
		g = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60);
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_count(logic [4:0] c);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic table_row_t row(logic op, logic [3:0] idx, logic [15:0] m,
		logic [47:0] x, logic [47:0] v, logic [47:0] a, logic [15:0] ts, int cnt);
		table_row_t t;
		t.op = op;
		t.idx = idx;
		t.mass = m;
		t.pos = x;
		t.vel = v;
		t.acc = a;
		t.ts = ts;
		t.cnt = cnt;
		t.typed = 1'b0;
		t.res = '{default: '0};
		return t;
	endfunction

	initial begin
		table_row_t t;
		int n;
		int cnt;
		int u;
		int slot;
		bit held;
		logic [47:0] anchor;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = nbg_pkg::OP_LOAD;
		point_index = '0;
		body_mass = '0;
		start_position = '0;
		start_velocity = '0;
		start_acceleration = '0;
		time_step = '0;
		hold_req = 1'b0;
		typed_use = 1'b0;
		words_sent = 0;
		steps_sent = 0;
		cfg_writes = 0;
		held = 1'b0;
		foreach (loaded[i]) loaded[i] = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_tab.push_back(row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 256, 0));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 0, 65535, nbg_pkg::MAXV48,
			nbg_pkg::MINV48, 0, 0, -1));
		t = row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 0, 1);
		t.typed = 1'b1;
		t.res = '{idx: 0, pos: nbg_pkg::MAXV48, vel: nbg_pkg::MINV48, coin: 0, sat: 0,
			last: 1};
		dir_tab.push_back(t);
		dir_tab.push_back(row(nbg_pkg::OP_STEP, 15, 1, 0, 0, 0, 65535, -1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 0, 100, 48'd1000 << 16, 0, 0, 0, -1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 1, 1, 48'd1000 << 16, 48'd1 << 16,
			-48'sd5 <<< 16, 0, -1));
		dir_tab.push_back(row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 256, 2));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 0, 65535, 48'd1000 << 16, 0, 0, 0, -1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 1, 65535, (48'd1000 << 16) + 1, 0, 0, 0,
			-1));
		dir_tab.push_back(row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 128, -1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 0, 65535, 0, 0, nbg_pkg::MINV48, 0, -1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 1, 2, 48'd10 << 16, -48'sd3 <<< 16,
			nbg_pkg::MAXV48, 0, -1));
		dir_tab.push_back(row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 1, -1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 0, 3, -48'sd50 <<< 16, 48'd7 << 16, 0, 0,
			-1));
		dir_tab.push_back(row(nbg_pkg::OP_LOAD, 1, 5, 48'd50 << 16, 0, 48'd2 << 16, 0, -1));
		dir_tab.push_back(row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 256, -1));
		dir_tab.push_back(row(nbg_pkg::OP_STEP, 0, 1, 0, 0, 0, 65535, -1));

		foreach (dir_tab[k]) begin
			if (dir_tab[k].cnt >= 0) write_count(5'(dir_tab[k].cnt));
			typed_use = dir_tab[k].typed;
			typed_res = dir_tab[k].res;
			send_word(dir_tab[k].op, dir_tab[k].idx, dir_tab[k].mass, dir_tab[k].pos,
				dir_tab[k].vel, dir_tab[k].acc, dir_tab[k].ts);
			if (typed_use) begin
				@(negedge clk);
				typed_use = 1'b0;
			end
			gap_after();
		end

		while (words_sent < RANDOM_WORDS + dir_tab.size()) begin
			u = $urandom_range(0, 99);
			cnt = (u < 4) ? 0 : (u < 8) ? $urandom_range(16, 31) : $urandom_range(1, 5);
			write_count(5'(cnt));
			n = (cnt > 16) ? 16 : cnt;
			anchor = rand_value();
			for (int s = 0; s < n; s++) begin
				if (!loaded[s]) begin
					send_word(nbg_pkg::OP_LOAD, 4'(s), rand_mass(), rand_value(),
						rand_value(), rand_value(), 16'd0);
					gap_after();
				end
			end
			if (!held && n >= 3 && n <= 5 && words_sent > 100) begin
				held = 1'b1;
				hold_req = 1'b1;
				send_word(nbg_pkg::OP_STEP, 4'd0, 16'd1, '0, '0, '0, 16'd256);
				gap_after();
			end
			repeat ((n >= 16) ? 2 : $urandom_range(3, 9)) begin
				if ($urandom_range(0, 99) < 55) begin
					slot = (n > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1)
						: $urandom_range(0, 15);
					send_word(nbg_pkg::OP_LOAD, 4'(slot), rand_mass(),
						($urandom_range(0, 9) == 0) ? anchor : rand_value(),
						rand_value(), ($urandom_range(0, 4) == 0) ? rand48()
						: rand_value() >>> 8, 16'd0);
				end else begin
					send_word(nbg_pkg::OP_STEP, 4'($urandom), 16'($urandom), rand48(),
						rand48(), rand48(),
						($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 512)));
				end
				gap_after();
			end
		end

		settle();
		repeat (100) @(negedge clk);
		$display("Sent %0d words (%0d steps) over %0d count settings, checked %0d results.",
			words_sent, steps_sent, cfg_writes, results_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/nbg_pkg.sv
rtl/nbg_ram.sv
rtl/nbg_div.sv
rtl/nbody_1d_gravity_step.sv
tb/testbench.sv
